// ===== design/wled_pkg.sv =====
// Shared types for the window local extremum detector.
`default_nettype none

package wled_pkg;

    // Width of the window radius register, fixed by the register map.
    localparam int RADIUS_CFG_BITS = 5;

    // Reset value of the window radius register.
    localparam logic [RADIUS_CFG_BITS-1:0] RADIUS_RESET = 5'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } wled_state_t;

    // Control from the sequencer to the shared comparator.
    typedef struct packed {
        logic load;
        logic compare;
    } cmp_ctrl_t;

    // Status returned by the shared comparator.
    typedef struct packed {
        logic can_max;
        logic can_min;
    } cmp_stat_t;

endpackage

`default_nettype wire

// ===== design/window_local_extremum_detector_unit.sv =====
// Top level of the sliding window local extremum detector.
// Flow: a sample that fills the window is read back as centre, compared against each neighbor
// and any extremum is reported; no new sample is taken until that scan is done, else one per cycle;
// a result still held by a stalled sink keeps the block waiting until it is taken.
// Reset clears the fill count, the write slot and the sequencer, and sets the radius to 2.
// The window RAM needs no clearing; the fill count guards every read of it.
`default_nettype none

module window_local_extremum_detector_unit
    import wled_pkg::*;
#(
    parameter int MAX_RADIUS  = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    // Configuration: window_radius.
    input  wire logic                                          cfg_we,
    input  wire logic [RADIUS_CFG_BITS-1:0]                    cfg_data,
    // Input stream.
    input  wire logic                                          s_tvalid,
    output logic                                               s_tready,
    // s_tdata fields from bit 0: sample_value, sample_time, zero padding.
    input  wire logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0]    s_tdata,
    // s_tuser fields from bit 0: segment_start.
    input  wire logic                                          s_tuser,
    // Result stream.
    output logic                                               m_tvalid,
    input  wire logic                                          m_tready,
    // m_tdata fields from bit 0: peak_value, peak_time, zero padding.
    output logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0]         m_tdata,
    // m_tuser fields from bit 0: is_maximum.
    output logic                                               m_tuser
);

    // Ring depth covers the widest window, 2*MAX_RADIUS+1 samples.
    localparam int DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int A_W    = $clog2(DEPTH);
    localparam int F_W    = $clog2(DEPTH + 1);
    localparam int R_W    = $clog2(MAX_RADIUS + 1);
    localparam int WORD_W = SAMPLE_BITS + TIME_BITS;
    localparam int DATA_W = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8;

    wled_state_t state_reg;
    wled_state_t state_next;

    logic [RADIUS_CFG_BITS-1:0] radius_reg;
    logic [F_W-1:0]             fill_count_reg;
    logic [F_W-1:0]             fill_count_next;
    logic [A_W-1:0]             write_slot_reg;
    logic [A_W-1:0]             write_slot_next;
    logic [A_W-1:0]             newest_reg;
    logic [A_W-1:0]             newest_next;
    logic [F_W-1:0]             k_reg;
    logic [F_W-1:0]             k_next;
    logic                       iss_v_reg;
    logic                       iss_v_next;
    logic [TIME_BITS-1:0]       ctime_reg;

    logic                       m_tvalid_reg;
    logic                       m_tuser_reg;
    logic [DATA_W-1:0]          m_tdata_reg;

    logic                       accept;
    logic [R_W-1:0]             r_eff;
    logic [F_W-1:0]             span;
    logic [A_W-1:0]             slot_base;
    logic [F_W-1:0]             fill_base;
    logic                       window_full;
    logic [A_W:0]               centre_sum;
    logic [A_W:0]               nbr_sum;
    logic [A_W-1:0]             centre_addr;
    logic [A_W-1:0]             nbr_addr;
    logic [F_W-1:0]             k_plus1;
    logic                       issue;
    logic                       scan_done;
    logic                       found;
    logic                       out_free;
    logic                       out_load;
    logic [A_W-1:0]             rd_addr;
    logic [WORD_W-1:0]          rd_data;
    logic [WORD_W-1:0]          wr_data;
    cmp_ctrl_t                  cmp_ctrl;
    cmp_stat_t                  cmp_stat;
    logic signed [SAMPLE_BITS-1:0] centre_value;

    assign accept = s_tvalid && s_tready;

    // Radius zero acts as one; anything past the widest window is clamped.
    always_comb
    begin
        if (radius_reg == '0)
        begin
            r_eff = R_W'(1);
        end
        else if (int'(radius_reg) > MAX_RADIUS)
        begin
            r_eff = R_W'(MAX_RADIUS);
        end
        else
        begin
            r_eff = R_W'(radius_reg);
        end
    end

    assign span = F_W'({r_eff, 1'b1});

    // A segment start empties the window before this sample is stored.
    assign slot_base = s_tuser ? '0 : write_slot_reg;
    assign fill_base = s_tuser ? '0 : fill_count_reg;
    assign fill_count_next = (fill_base == F_W'(DEPTH)) ? fill_base : fill_base + 1'b1;
    assign write_slot_next = (slot_base == A_W'(DEPTH - 1)) ? '0 : slot_base + 1'b1;
    assign window_full = (fill_count_next >= span);

    // Ring addresses R places and k places behind the newest sample.
    assign centre_sum  = {1'b0, newest_reg} + (A_W+1)'(DEPTH) - (A_W+1)'(r_eff);
    assign centre_addr = (centre_sum >= (A_W+1)'(DEPTH)) ?
                         A_W'(centre_sum - (A_W+1)'(DEPTH)) : A_W'(centre_sum);
    assign nbr_sum     = {1'b0, newest_reg} + (A_W+1)'(DEPTH) - (A_W+1)'(k_reg);
    assign nbr_addr    = (nbr_sum >= (A_W+1)'(DEPTH)) ?
                         A_W'(nbr_sum - (A_W+1)'(DEPTH)) : A_W'(nbr_sum);

    // The neighbor scan walks k over the span and steps over the centre itself.
    assign k_plus1   = k_reg + 1'b1;
    assign scan_done = (k_reg >= span) && !iss_v_reg;
    assign found     = cmp_stat.can_max || cmp_stat.can_min;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && window_full)
                begin
                    state_next = ST_CENTRE;
                end
            end
            ST_CENTRE:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!found || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready         = 1'b0;
        rd_addr          = nbr_addr;
        issue            = 1'b0;
        cmp_ctrl.load    = 1'b0;
        cmp_ctrl.compare = 1'b0;
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_CENTRE:
            begin
                rd_addr = centre_addr;
            end
            ST_LOAD:
            begin
                cmp_ctrl.load = 1'b1;
                issue         = (k_reg < span);
            end
            ST_SCAN:
            begin
                issue            = (k_reg < span);
                cmp_ctrl.compare = iss_v_reg;
            end
            ST_DONE:
            begin
                out_load = found && out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        newest_next = newest_reg;
        k_next      = k_reg;
        iss_v_next  = 1'b0;
        if (accept)
        begin
            newest_next = slot_base;
            k_next      = '0;
        end
        else if (issue)
        begin
            iss_v_next = 1'b1;
            k_next     = (k_plus1 == F_W'(r_eff)) ? k_reg + F_W'(2) : k_plus1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            radius_reg     <= RADIUS_RESET;
            fill_count_reg <= '0;
            write_slot_reg <= '0;
            newest_reg     <= '0;
            k_reg          <= '0;
            iss_v_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            k_reg      <= k_next;
            iss_v_reg  <= iss_v_next;
            if (cfg_we)
            begin
                radius_reg <= cfg_data;
            end
            if (accept)
            begin
                fill_count_reg <= fill_count_next;
                write_slot_reg <= write_slot_next;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Centre time stamp and result payload.
    always_ff @(posedge clk)
    begin
        if (cmp_ctrl.load)
        begin
            ctime_reg <= rd_data[WORD_W-1:SAMPLE_BITS];
        end
        if (out_load)
        begin
            m_tuser_reg <= cmp_stat.can_max;
            m_tdata_reg <= DATA_W'({ctime_reg, centre_value});
        end
    end

    assign wr_data = s_tdata[WORD_W-1:0];

    wled_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (slot_base),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    wled_cmp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cmp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cmp_ctrl),
        .sample (rd_data[SAMPLE_BITS-1:0]),
        .centre (centre_value),
        .stat   (cmp_stat)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // A neighbor read is only in flight while the scan runs.
    a_issue_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        iss_v_reg |-> (state_reg == ST_SCAN))
        else $error("neighbor read outside the scan");

    // Every window has neighbors, so a finished scan cannot leave both kinds open.
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !(cmp_stat.can_max && cmp_stat.can_min))
        else $error("centre reported as both maximum and minimum");

    // A scan only starts once the window holds the whole span.
    a_full_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CENTRE) |-> (fill_count_reg >= span))
        else $error("scan started on a partial window");

    // Ring pointers stay inside the ring.
    a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (write_slot_reg < A_W'(DEPTH)) && (fill_count_reg <= F_W'(DEPTH)))
        else $error("ring pointer out of range");

    // A result is only loaded into a free output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> !$past(out_load))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== design/wled_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wled_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 33
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/wled_cmp.sv =====
// Shared signed comparator that tests the centre sample against each neighbor.
`default_nettype none

module wled_cmp
    import wled_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cmp_ctrl_t                     ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed      [SAMPLE_BITS-1:0] centre,
    output cmp_stat_t                          stat
);

    logic signed [SAMPLE_BITS-1:0] centre_reg;
    logic                          can_max_reg;
    logic                          can_max_next;
    logic                          can_min_reg;
    logic                          can_min_next;

    always_comb
    begin
        can_max_next = can_max_reg;
        can_min_next = can_min_reg;
        if (ctrl.load)
        begin
            can_max_next = 1'b1;
            can_min_next = 1'b1;
        end
        else if (ctrl.compare)
        begin
            // A tie with a neighbor rules out the kind of extremum it touches.
            if (centre_reg <= sample)
            begin
                can_max_next = 1'b0;
            end
            if (centre_reg >= sample)
            begin
                can_min_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            centre_reg <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            can_max_reg <= 1'b0;
            can_min_reg <= 1'b0;
        end
        else
        begin
            can_max_reg <= can_max_next;
            can_min_reg <= can_min_next;
        end
    end

    assign centre       = centre_reg;
    assign stat.can_max = can_max_reg;
    assign stat.can_min = can_min_reg;

endmodule

`default_nettype wire

// ===== bench/window_local_extremum_detector_unit_test.sv =====
// Self-checking testbench for the sliding window local extremum detector.
`default_nettype none

module window_local_extremum_detector_unit_test;
    import wled_pkg::*;

    localparam int MAX_RADIUS  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int TIME_BITS   = 32;
    localparam int RING_DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int DATA_BITS   = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8;
    // Covers a scan of the widest window plus a margin, so that the block is idle afterwards.
    localparam int IDLE_PAD    = 2 * MAX_RADIUS + 13;

    // One reported extremum: the fields of m_tuser and m_tdata.
    typedef struct packed {
        logic                          is_maximum;
        logic signed [SAMPLE_BITS-1:0] peak_value;
        logic [TIME_BITS-1:0]          peak_time;
    } peak_report_t;

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       cfg_we   = 1'b0;
    logic [RADIUS_CFG_BITS-1:0] cfg_data = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    // s_tdata fields from bit 0: sample_value, sample_time.
    logic [DATA_BITS-1:0]       s_tdata  = '0;
    // s_tuser fields from bit 0: segment_start.
    logic                       s_tuser  = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    // m_tdata fields from bit 0: peak_value, peak_time.
    logic [DATA_BITS-1:0]       m_tdata;
    // m_tuser fields from bit 0: is_maximum.
    logic                       m_tuser;

    // Extrema that the block still owes, oldest first.
    peak_report_t peaks_due[$];
    int           fail_count = 0;

    // Shadow copy of the detector: sample ring, segment fill, write slot and radius register.
    logic signed [SAMPLE_BITS-1:0] ring_value[RING_DEPTH];
    logic [TIME_BITS-1:0]          ring_stamp[RING_DEPTH];
    int                            seg_fill   = 0;
    int                            next_slot  = 0;
    logic [RADIUS_CFG_BITS-1:0]    radius_now = RADIUS_RESET;

    // Sender burst bookkeeping and receiver stall pattern.
    int burst_left = 0;
    int ready_run  = 0;

    window_local_extremum_detector_unit #(
        .MAX_RADIUS  (MAX_RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The register value 0 behaves as radius 1, and anything above the maximum as the maximum.
    function automatic int clamp_radius(input logic [RADIUS_CFG_BITS-1:0] raw);
        int r;
        r = raw;
        if (r < 1)
            r = 1;
        if (r > MAX_RADIUS)
            r = MAX_RADIUS;
        return r;
    endfunction

    // Takes one sample into the shadow ring and tells whether the centre of the window
    // becomes a strict local maximum or minimum; the report comes back through rep.
    function automatic bit predict_peak(input logic signed [SAMPLE_BITS-1:0] value,
                                        input logic [TIME_BITS-1:0] stamp,
                                        input logic start,
                                        output peak_report_t rep);
        int                            newest;
        int                            r;
        int                            span;
        int                            centre;
        int                            slot;
        logic signed [SAMPLE_BITS-1:0] mid;
        bit                            above_all;
        bit                            below_all;
        above_all = 1'b1;
        below_all = 1'b1;
        rep = '0;
        if (start)
        begin
            seg_fill  = 0;
            next_slot = 0;
        end
        newest = next_slot;
        ring_value[newest] = value;
        ring_stamp[newest] = stamp;
        next_slot = (newest + 1) % RING_DEPTH;
        if (seg_fill < RING_DEPTH)
            seg_fill++;
        r    = clamp_radius(radius_now);
        span = 2 * r + 1;
        if (seg_fill < span)
            return 1'b0;
        centre = (newest + RING_DEPTH - r) % RING_DEPTH;
        mid    = ring_value[centre];
        for (int k = 0; k < span; k++)
        begin
            if (k != r)
            begin
                slot = (newest + RING_DEPTH - k) % RING_DEPTH;
                // A tie rules out whichever kind of extremum it touches.
                if (mid <= ring_value[slot])
                    above_all = 1'b0;
                if (mid >= ring_value[slot])
                    below_all = 1'b0;
            end
        end
        if (!above_all && !below_all)
            return 1'b0;
        rep.is_maximum = above_all;
        rep.peak_value = mid;
        rep.peak_time  = ring_stamp[centre];
        return 1'b1;
    endfunction

    // Offers one sample and returns at the edge where its transaction completes.
    // Samples go out in bursts of random length; between bursts tvalid sometimes drops for a while.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                               input logic [TIME_BITS-1:0] stamp,
                               input logic start);
        peak_report_t rep;
        int           gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, value};
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (predict_peak(value, stamp, start, rep))
            peaks_due.push_back(rep);
    endtask

    // Stops offering samples, lets every owed extremum arrive, then lets a
    // scan that produces nothing run out before anything else happens.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (peaks_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic write_radius(input logic [RADIUS_CFG_BITS-1:0] raw);
        cfg_we   <= 1'b1;
        cfg_data <= raw;
        @(posedge clk);
        cfg_we     <= 1'b0;
        radius_now  = raw;
    endtask

    // Radius after reset is 2. The first window puts the largest sample in the centre,
    // the next has a tie and no extremum, the third has the smallest sample in the centre.
    // Time stamps at both ends of their range ride along.
    task automatic check_reset_radius();
        send_sample(16'sd0, 32'd0, 1'b1);
        send_sample(16'sd5, 32'd1, 1'b0);
        send_sample(16'sh7FFF, 32'hFFFF_FFFF, 1'b0);
        send_sample(16'sd5, 32'd3, 1'b0);
        send_sample(16'sh8000, 32'd0, 1'b0);
        send_sample(16'sd7, 32'd5, 1'b0);
        send_sample(16'sd7, 32'd6, 1'b0);
    endtask

    // A zero radius acts as one. Flat windows and windows with equal neighbours give
    // nothing, a single dip gives a minimum.
    task automatic check_radius_floor();
        wait_idle();
        write_radius('0);
        send_sample(16'sd3, 32'd100, 1'b1);
        send_sample(16'sd3, 32'd101, 1'b0);
        send_sample(16'sd3, 32'd102, 1'b0);
        send_sample(16'sd1, 32'd103, 1'b0);
        send_sample(16'sd3, 32'd104, 1'b0);
        send_sample(16'sd4, 32'd105, 1'b0);
        send_sample(16'sd4, 32'd106, 1'b0);
    endtask

    // The radius grows from 1 to 3 in the middle of a segment; the wider window
    // reaches back into samples taken under the old radius.
    task automatic check_mid_segment_radius_change();
        wait_idle();
        write_radius(5'd1);
        send_sample(16'sd10, 32'd200, 1'b1);
        send_sample(16'sd20, 32'd201, 1'b0);
        send_sample(16'sd10, 32'd202, 1'b0);
        wait_idle();
        write_radius(5'd3);
        send_sample(16'sd30, 32'd203, 1'b0);
        send_sample(16'sd5, 32'd204, 1'b0);
        send_sample(16'sd1, 32'd205, 1'b0);
        send_sample(16'sd0, 32'd206, 1'b0);
    endtask

    // Random segments under one radius setting. Most segments are long enough to fill
    // the window; some are cut short, and now and then a stray segment start breaks one.
    // Each segment draws its samples in one style: a small random walk, fully random
    // values, a tiny set of values that makes ties common, or the range extremes.
    task automatic check_random_segments(input logic [RADIUS_CFG_BITS-1:0] raw,
                                         input int n_items);
        int                   sent;
        int                   seg_len;
        int                   span;
        int                   style;
        bit                   carry_on;
        bit                   stamp_counts;
        logic                 start;
        logic [SAMPLE_BITS-1:0] level;
        logic [TIME_BITS-1:0] stamp;
        wait_idle();
        write_radius(raw);
        span     = 2 * clamp_radius(raw) + 1;
        sent     = 0;
        // Half the time the open segment carries on under the new radius.
        carry_on = 1'($urandom_range(0, 1));
        while (sent < n_items)
        begin
            if ($urandom_range(0, 4) == 0)
                seg_len = $urandom_range(1, span);
            else
                seg_len = span + $urandom_range(0, 60);
            style        = $urandom_range(0, 3);
            level        = SAMPLE_BITS'($urandom);
            stamp        = $urandom;
            stamp_counts = 1'($urandom_range(0, 1));
            for (int k = 0; k < seg_len && sent < n_items; k++)
            begin
                start = (k == 0) && !(sent == 0 && carry_on);
                if ($urandom_range(0, 49) == 0)
                    start = 1'b1;
                case (style)
                    0: level = level + SAMPLE_BITS'($urandom_range(0, 6)) - 16'd3;
                    1: level = SAMPLE_BITS'($urandom);
                    2: level = SAMPLE_BITS'($urandom_range(0, 3)) - 16'd1;
                    default:
                        case ($urandom_range(0, 3))
                            0: level = 16'h8000;
                            1: level = 16'h7FFF;
                            2: level = 16'h0000;
                            default: level = 16'hFFFF;
                        endcase
                endcase
                stamp = stamp_counts ? stamp + 32'd1 : 32'($urandom);
                send_sample(level, stamp, start);
                sent++;
            end
        end
    endtask

    // Receiver: alternating runs of ready and stall with random lengths, with an
    // occasional long run of ready so that some stretches see no back pressure.
    always @(posedge clk)
    begin
        if (ready_run > 0)
            ready_run <= ready_run - 1;
        else
        begin
            m_tready <= !m_tready;
            if (!m_tready)
                ready_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(0, 15);
            else
                ready_run <= $urandom_range(0, 11);
        end
    end

    // Every result transaction is matched against the oldest owed extremum.
    always @(posedge clk)
    begin : result_check
        peak_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (peaks_due.size() == 0)
            begin
                $error("unexpected result: is_maximum %0b, peak_value %0d, peak_time %0d",
                       m_tuser, $signed(m_tdata[SAMPLE_BITS-1:0]),
                       m_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS]);
                fail_count++;
            end
            else
            begin
                want = peaks_due.pop_front();
                if (m_tuser !== want.is_maximum)
                begin
                    $error("is_maximum mismatch: expected %0b, got %0b",
                           want.is_maximum, m_tuser);
                    fail_count++;
                end
                if (m_tdata[SAMPLE_BITS-1:0] !== want.peak_value)
                begin
                    $error("peak_value mismatch: expected %0d, got %0d",
                           want.peak_value, $signed(m_tdata[SAMPLE_BITS-1:0]));
                    fail_count++;
                end
                if (m_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS] !== want.peak_time)
                begin
                    $error("peak_time mismatch: expected %0d, got %0d",
                           want.peak_time, m_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reset_radius();
        check_radius_floor();
        check_mid_segment_radius_change();

        // Radius settings: the maximum, all ones (clamped), the minimum, the reset
        // value, zero (floored), another clamped value and a few in between.
        check_random_segments(5'd16, 150);
        check_random_segments(5'd31, 150);
        check_random_segments(5'd1, 150);
        check_random_segments(5'd2, 120);
        check_random_segments(5'd0, 100);
        check_random_segments(5'd20, 100);
        repeat (3) check_random_segments(RADIUS_CFG_BITS'($urandom_range(3, 15)), 110);

        wait_idle();
        if (fail_count == 0 && peaks_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
